/* hw/rtl/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg: shared types and codes of the integer matrix multiply unit
// Request function codes, register indexes, the command that the front end
// queues for the back end, and the set of effective matrix dimensions.
// ----------------------------------------------------------------------------
package imm_pkg;

	// Side of the square element stores. The four-bit row and column fields
	// address exactly this many entries.
	localparam int MAX_DIM = 16;

	// Request function codes.
	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_ROW    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROWS_A = 2'd0;
	localparam logic [1:0] CFG_INNER  = 2'd1;
	localparam logic [1:0] CFG_COLS_B = 2'd2;

	// Width and reset value of the dimension registers.
	localparam int          DIM_W     = 5;
	localparam logic [4:0]  DIM_RESET = 5'd16;

	// Entries in the command queue between front and back end.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_ROW
	} op_t;

	// One classified command.
	typedef struct packed {
		op_t         op;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] value;
	} cmd_t;

	// Effective dimensions, already limited to the store size.
	typedef struct packed {
		logic [4:0] rows_a;
		logic [4:0] inner;
		logic [4:0] cols_b;
	} dims_t;

endpackage

/* hw/rtl/imm_front.sv */
// ----------------------------------------------------------------------------
// imm_front: request classifier
// Decodes each incoming request, drops the ones that have no effect and
// turns the rest into queued commands.
// ----------------------------------------------------------------------------
module imm_front (
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	input  imm_pkg::dims_t     dims,
	input  logic               q_full,
	output logic               q_push,
	output imm_pkg::cmd_t      q_cmd
);

	logic keep;
	logic in_store;

	// A load outside the store is ignored.
	assign in_store = (int'(row) < imm_pkg::MAX_DIM) && (int'(col) < imm_pkg::MAX_DIM);

	always_comb begin
		q_cmd.row   = row;
		q_cmd.col   = col;
		q_cmd.value = value;
		unique case (func)
			imm_pkg::FUNC_LOAD_A: begin
				q_cmd.op = imm_pkg::OP_LOAD_A;
				keep     = in_store;
			end
			imm_pkg::FUNC_LOAD_B: begin
				q_cmd.op = imm_pkg::OP_LOAD_B;
				keep     = in_store;
			end
			imm_pkg::FUNC_ROW: begin
				q_cmd.op = imm_pkg::OP_ROW;
				keep     = ({1'b0, row} < dims.rows_a) && (dims.cols_b != '0);
			end
			default: begin
				q_cmd.op = imm_pkg::OP_ROW;
				keep     = 1'b0;
			end
		endcase
	end

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full && keep;

endmodule

/* hw/rtl/imm_fifo.sv */
// ----------------------------------------------------------------------------
// imm_fifo: command queue
// A small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module imm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  imm_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output imm_pkg::cmd_t head
);

	localparam int PW = $clog2(imm_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(imm_pkg::QUEUE_DEPTH + 1);

	imm_pkg::cmd_t entry_q [imm_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(imm_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(imm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(imm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/imm_back.sv */
// ----------------------------------------------------------------------------
// imm_back: matrix store and multiply-accumulate engine
// Executes queued commands: loads write the matrix memories, row commands
// run one multiply-accumulate per cycle and deliver one result per column.
// ----------------------------------------------------------------------------
module imm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  imm_pkg::dims_t     dims,
	input  logic               head_valid,
	input  imm_pkg::cmd_t      head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         out_row,
	output logic [3:0]         out_col,
	output logic signed [31:0] product,
	output logic               last
);

	localparam int DEPTH = imm_pkg::MAX_DIM * imm_pkg::MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [3:0]  row_q;
	logic [4:0]  c_q;
	logic [4:0]  k_q;
	logic [31:0] acc_q;
	logic        valid_s1;
	logic        valid_s2;
	logic [31:0] a_rd_s1;
	logic [31:0] b_rd_s1;
	logic [31:0] mul_s2;

	logic [31:0] mem_a [DEPTH];
	logic [31:0] mem_b [DEPTH];

	logic          issue;
	logic          load_a;
	logic          load_b;
	logic          out_free;
	logic          emit;
	logic          col_last;
	logic [AW-1:0] load_addr;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign load_a   = pop && (head.op == imm_pkg::OP_LOAD_A);
	assign load_b   = pop && (head.op == imm_pkg::OP_LOAD_B);
	assign issue    = (state_q == ST_RUN) && (k_q < dims.inner);
	assign out_free = !res_valid || !res_stall;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign col_last = ({1'b0, c_q} + 6'd1) == {1'b0, dims.cols_b};

	assign load_addr = AW'(int'(head.row) * imm_pkg::MAX_DIM + int'(head.col));
	assign rd_addr_a = AW'(int'(row_q) * imm_pkg::MAX_DIM + int'(k_q));
	assign rd_addr_b = AW'(int'(k_q) * imm_pkg::MAX_DIM + int'(c_q));

	// Matrix memories, read stage and multiplier stage.
	always_ff @(posedge clk) begin
		if (load_a) begin
			mem_a[load_addr] <= head.value;
		end
		if (load_b) begin
			mem_b[load_addr] <= head.value;
		end
		if (issue) begin
			a_rd_s1 <= mem_a[rd_addr_a];
			b_rd_s1 <= mem_b[rd_addr_b];
		end
		if (valid_s1) begin
			mul_s2 <= a_rd_s1 * b_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			c_q       <= '0;
			k_q       <= '0;
			acc_q     <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
			out_row   <= '0;
			out_col   <= '0;
			product   <= '0;
			last      <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				acc_q <= acc_q + mul_s2;
			end
			if (res_valid && !res_stall && !emit) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (head.op == imm_pkg::OP_ROW)) begin
						row_q   <= head.row;
						c_q     <= '0;
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid <= 1'b1;
						out_row   <= row_q;
						out_col   <= c_q[3:0];
						product   <= acc_q;
						last      <= col_last;
						acc_q     <= '0;
						k_q       <= '0;
						if (col_last) begin
							state_q <= ST_IDLE;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/integer_matrix_multiply_unit.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit: signed 32-bit integer matrix product engine
// Holds two matrices, takes element loads and computes one product row per
// request, one dot product per column.
// ----------------------------------------------------------------------------
// The unit stores matrix A (rows_a by inner) and matrix B (inner by cols_b),
// each in a MAX_DIM by MAX_DIM word memory. A request with func 0 or 1 writes
// one element of A or B and gives no result; a request with func 2 computes
// row "row" of A times B and returns cols_b results in column order, each the
// dot product over inner terms wrapped to 32 bits, with last set on the final
// column. Rows at or beyond rows_a, loads outside the store and func 3 are
// dropped. Requests enter a four-entry command queue, so the sender keeps
// going while the engine works. A row request first leaves the idle state;
// then, for each column, the single multiply-accumulate unit handles one
// inner term per cycle, after which the column closes its loop, drains the
// memory read and multiplier stages and moves the sum into the result
// register. The result register lets the engine start the next column
// while a finished result waits to be taken. Entries must be loaded before
// a row request reads them. The dimension registers may be changed only
// while the unit is idle; values above MAX_DIM act as MAX_DIM.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel.
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	// Result channel.
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         out_row,
	output logic [3:0]         out_col,
	output logic signed [31:0] product,
	output logic               last,
	// Configuration write port.
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_wdata
);

	logic [4:0] rows_a_q;
	logic [4:0] inner_q;
	logic [4:0] cols_b_q;

	imm_pkg::dims_t dims;
	imm_pkg::cmd_t  q_cmd;
	imm_pkg::cmd_t  q_head;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_head_valid;

	// Dimension registers. Writes to the unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= imm_pkg::DIM_RESET;
			inner_q  <= imm_pkg::DIM_RESET;
			cols_b_q <= imm_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imm_pkg::CFG_ROWS_A: rows_a_q <= cfg_wdata;
				imm_pkg::CFG_INNER:  inner_q  <= cfg_wdata;
				imm_pkg::CFG_COLS_B: cols_b_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Limit each dimension to the store size.
	assign dims.rows_a = (int'(rows_a_q) > imm_pkg::MAX_DIM) ?
		imm_pkg::DIM_W'(imm_pkg::MAX_DIM) : rows_a_q;
	assign dims.inner  = (int'(inner_q) > imm_pkg::MAX_DIM) ?
		imm_pkg::DIM_W'(imm_pkg::MAX_DIM) : inner_q;
	assign dims.cols_b = (int'(cols_b_q) > imm_pkg::MAX_DIM) ?
		imm_pkg::DIM_W'(imm_pkg::MAX_DIM) : cols_b_q;

	imm_front u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func     (func),
		.row      (row),
		.col      (col),
		.value    (value),
		.dims     (dims),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	imm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head      (q_head)
	);

	imm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.head_valid(q_head_valid),
		.head      (q_head),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	// The queue must never be written while it is full.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("command queue written while full");

	// A delivered column lies inside the product matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, out_col} < dims.cols_b))
		else $error("result column beyond cols_b");

	// A delivered row lies inside the product matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, out_row} < dims.rows_a))
		else $error("result row beyond rows_a");
`endif

endmodule
